// ===== src/frrq_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// frrq_pkg
// Shared codes, port widths and controller/datapath interface structs.
// ============================================================================
package frrq_pkg;

    // Handle slots held in configuration registers
    localparam int NUM_SLOTS = 4;

    // Port widths
    localparam int TIME_W      = 63;
    localparam int IN_TDATA_W  = 104;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 168;
    localparam int OUT_TUSER_W = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CONN_FILTER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_A       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_B       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_C       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_D       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 3'd5;

    // Input actions
    localparam logic [1:0] ACT_BEAT    = 2'd0;
    localparam logic [1:0] ACT_READ    = 2'd1;
    localparam logic [1:0] ACT_DISABLE = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_QUEUED   = 3'd0;
    localparam logic [2:0] KIND_PASSED   = 3'd1;
    localparam logic [2:0] KIND_BYTE     = 3'd2;
    localparam logic [2:0] KIND_EMPTY    = 3'd3;
    localparam logic [2:0] KIND_DISABLED = 3'd4;

    // Controller -> datapath
    typedef struct packed {
        logic in_ready;  // input side may take an item
        logic accept;    // item taken this cycle
        logic copy_rd;   // read one staging byte toward the ring
        logic age_calc;  // compute age of the report being read
        logic emit;      // load one report byte into the output register
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic in_valid;   // upstream offers an item
        logic out_free;   // output register can take a result
        logic goes_copy;  // offered item is a last beat that will be queued
        logic goes_read;  // offered item is a read of a non-empty ring
        logic copy_end;   // current staging byte is the last of the report
        logic read_end;   // current report byte is the last of the report
    } t_dp_sts;

endpackage

// ===== src/frrq_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// frrq_ctrl
// Sequencer: idle/accept, staging-to-ring copy, report read-out.
// ============================================================================
module frrq_ctrl
    import frrq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_COPY  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_AGE   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = i_sts.out_free;
                o_cmd.accept   = i_sts.out_free & i_sts.in_valid;
                if (o_cmd.accept && i_sts.goes_copy) begin
                    n_state = S_COPY;
                end else if (o_cmd.accept && i_sts.goes_read) begin
                    n_state = S_AGE;
                end
            end
            S_COPY: begin
                o_cmd.copy_rd = 1'b1;
                if (i_sts.copy_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last ring write lands this cycle
                n_state = S_IDLE;
            end
            S_AGE: begin
                o_cmd.age_calc = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = i_sts.out_free;
                if (i_sts.out_free && i_sts.read_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/frrq_datapath.sv =====
`timescale 1ns / 1ps
// ============================================================================
// frrq_datapath
// Config registers, staging buffer, ring memories, statistics, output stage.
// ============================================================================
module frrq_datapath
    import frrq_pkg::*;
#(
    parameter int QUEUE_DEPTH    = 64,
    parameter int MAX_REPORT_LEN = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [IN_TUSER_W-1:0]  i_s_tuser,
    input  logic                   i_s_tlast,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic [OUT_TUSER_W-1:0] o_m_tuser,
    output logic                   o_m_tlast,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts
);

    localparam int QW   = $clog2(QUEUE_DEPTH);
    localparam int OW   = $clog2(QUEUE_DEPTH + 1);
    localparam int LW   = $clog2(MAX_REPORT_LEN + 1);
    localparam int SW   = (MAX_REPORT_LEN > 1) ? $clog2(MAX_REPORT_LEN) : 1;
    localparam int RING = QUEUE_DEPTH * MAX_REPORT_LEN;
    localparam int BAW  = (RING > 1) ? $clog2(RING) : 1;

    // input fields
    logic [1:0]        w_action;
    logic              w_present;
    logic [15:0]       w_conn;
    logic [15:0]       w_handle;
    logic [7:0]        w_byte;
    logic [TIME_W-1:0] w_now;

    assign w_action  = i_s_tuser[1:0];
    assign w_present = i_s_tuser[2];
    assign w_conn    = i_s_tdata[15:0];
    assign w_handle  = i_s_tdata[31:16];
    assign w_byte    = i_s_tdata[39:32];
    assign w_now     = i_s_tdata[102:40];

    // configuration
    logic [15:0] r_conn_filter;
    logic [15:0] r_slot [NUM_SLOTS];
    logic [2:0]  r_slots_in_use;
    logic        w_cfg_hit;

    // queue state and statistics
    logic [QW-1:0] r_rp,   n_rp;
    logic [OW-1:0] r_occ,  n_occ;
    logic [OW-1:0] r_peak, n_peak;
    logic [31:0]   r_acc,  n_acc;
    logic [31:0]   r_drop, n_drop;
    logic          r_cap,  n_cap;
    logic [LW-1:0] r_slen, n_slen;
    logic          r_sovf, n_sovf;

    // memories
    logic [7:0]        r_stg        [MAX_REPORT_LEN];
    logic [7:0]        r_ring_bytes [RING];
    logic [15:0]       r_ring_hdl   [QUEUE_DEPTH];
    logic [LW-1:0]     r_ring_len   [QUEUE_DEPTH];
    logic [TIME_W-1:0] r_ring_stamp [QUEUE_DEPTH];

    // sequencing registers
    logic [LW-1:0]     r_idx;
    logic [LW-1:0]     r_copy_len;
    logic [QW-1:0]     r_tail;
    logic [QW-1:0]     r_slot_rd;
    logic [TIME_W-1:0] r_now;
    logic [7:0]        r_stg_rd;
    logic              r_wr_pend;
    logic [LW-1:0]     r_wr_idx;
    logic [15:0]       r_hdl_rd;
    logic [LW-1:0]     r_len_rd;
    logic [TIME_W-1:0] r_stamp_rd;
    logic [7:0]        r_byte_rd;
    logic [TIME_W-1:0] r_age;

    // output register
    logic              r_ov;
    logic [2:0]        r_o_kind;
    logic [15:0]       r_o_handle;
    logic [7:0]        r_o_byte;
    logic              r_o_last;
    logic [TIME_W-1:0] r_o_age;
    logic [6:0]        r_o_queued;
    logic [6:0]        r_o_peak;
    logic [31:0]       r_o_recv;
    logic [31:0]       r_o_drop;
    logic              r_o_filter;

    logic              w_load;
    logic [2:0]        w_kind;
    logic [15:0]       w_o_handle;
    logic [7:0]        w_o_byte;
    logic              w_o_last;
    logic [TIME_W-1:0] w_o_age;

    // staging / match / ring address logic
    logic            w_stage_wr;
    logic [LW-1:0]   w_len_new;
    logic            w_ovf_new;
    logic            w_match;
    logic            w_goes_copy;
    logic            w_goes_read;
    logic            w_full;
    logic [QW-1:0]   w_rp_inc;
    logic [OW:0]     w_tail_sum;
    logic [QW-1:0]   w_tail;
    logic            w_out_free;
    logic            w_read_end;
    logic            w_byte_rd_en;
    logic [BAW-1:0]  w_rd_addr;
    logic [BAW-1:0]  w_wr_addr;

    assign w_stage_wr = w_present && (r_slen < LW'(MAX_REPORT_LEN));
    assign w_len_new  = r_slen + LW'(w_stage_wr);
    assign w_ovf_new  = r_sovf | (w_present & ~w_stage_wr);

    always_comb begin
        w_match = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if ((3'(i) < r_slots_in_use) && (r_slot[i] == w_handle)) begin
                w_match = 1'b1;
            end
        end
        w_match = w_match & r_cap & (w_conn == r_conn_filter);
    end

    assign w_goes_copy = (w_action == ACT_BEAT) && i_s_tlast && (w_len_new != '0)
                         && !w_ovf_new && w_match;
    assign w_goes_read = (w_action == ACT_READ) && (r_occ != '0);

    assign w_full     = (r_occ == OW'(QUEUE_DEPTH));
    assign w_rp_inc   = (r_rp == QW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QW'(1);
    assign w_tail_sum = (OW + 1)'(r_rp) + (OW + 1)'(r_occ);
    // full ring: the new entry takes the oldest slot
    assign w_tail     = w_full ? r_rp :
                        (w_tail_sum >= (OW + 1)'(QUEUE_DEPTH)) ?
                        QW'(w_tail_sum - (OW + 1)'(QUEUE_DEPTH)) : QW'(w_tail_sum);

    assign w_out_free = !r_ov || i_m_tready;
    assign w_read_end = (r_idx == r_len_rd - LW'(1));

    assign w_byte_rd_en = (i_cmd.accept && w_goes_read) || (i_cmd.emit && !w_read_end);
    assign w_rd_addr    = i_cmd.accept ? BAW'(r_rp) * BAW'(MAX_REPORT_LEN)
                        : BAW'(r_slot_rd) * BAW'(MAX_REPORT_LEN) + BAW'(r_idx) + BAW'(1);
    assign w_wr_addr    = BAW'(r_tail) * BAW'(MAX_REPORT_LEN) + BAW'(r_wr_idx);

    assign w_cfg_hit = i_cfg_wr_en && (i_cfg_index <= CFG_SLOTS_IN_USE);

    // status to controller
    assign o_sts.in_valid  = i_s_tvalid;
    assign o_sts.out_free  = w_out_free;
    assign o_sts.goes_copy = w_goes_copy;
    assign o_sts.goes_read = w_goes_read;
    assign o_sts.copy_end  = (r_idx == r_copy_len - LW'(1));
    assign o_sts.read_end  = w_read_end;

    assign o_s_tready = i_cmd.in_ready;

    // next state of queue, statistics and result selection
    always_comb begin
        n_rp       = r_rp;
        n_occ      = r_occ;
        n_peak     = r_peak;
        n_acc      = r_acc;
        n_drop     = r_drop;
        n_cap      = r_cap;
        n_slen     = r_slen;
        n_sovf     = r_sovf;
        w_load     = 1'b0;
        w_kind     = KIND_PASSED;
        w_o_handle = '0;
        w_o_byte   = '0;
        w_o_last   = 1'b1;
        w_o_age    = '0;

        if (i_cmd.accept) begin
            unique case (w_action)
                ACT_BEAT: begin
                    n_slen = w_len_new;
                    n_sovf = w_ovf_new;
                    if (i_s_tlast) begin
                        n_slen = '0;
                        n_sovf = 1'b0;
                        w_load = 1'b1;
                        if (w_goes_copy) begin
                            w_kind = KIND_QUEUED;
                            if (w_full) begin
                                n_rp   = w_rp_inc;
                                n_drop = r_drop + 32'd1;
                            end else begin
                                n_occ = r_occ + OW'(1);
                            end
                            n_acc = r_acc + 32'd1;
                            if (n_occ > r_peak) begin
                                n_peak = n_occ;
                            end
                        end
                    end
                end
                ACT_READ: begin
                    if (r_occ == '0) begin
                        w_load = 1'b1;
                        w_kind = KIND_EMPTY;
                    end else begin
                        n_rp  = w_rp_inc;
                        n_occ = r_occ - OW'(1);
                    end
                end
                ACT_DISABLE: begin
                    n_cap  = 1'b0;
                    n_rp   = '0;
                    n_occ  = '0;
                    w_load = 1'b1;
                    w_kind = KIND_DISABLED;
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.emit) begin
            w_load     = 1'b1;
            w_kind     = KIND_BYTE;
            w_o_handle = r_hdl_rd;
            w_o_byte   = r_byte_rd;
            w_o_last   = w_read_end;
            w_o_age    = r_age;
        end

        // re-arm on any write to a known register index
        if (w_cfg_hit) begin
            n_rp   = '0;
            n_occ  = '0;
            n_peak = '0;
            n_acc  = '0;
            n_drop = '0;
            n_cap  = 1'b1;
            n_slen = '0;
            n_sovf = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conn_filter  <= '0;
            r_slots_in_use <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_slot[i] <= '0;
            end
            r_rp      <= '0;
            r_occ     <= '0;
            r_peak    <= '0;
            r_acc     <= '0;
            r_drop    <= '0;
            r_cap     <= 1'b0;
            r_slen    <= '0;
            r_sovf    <= 1'b0;
            r_idx     <= '0;
            r_wr_pend <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_CONN_FILTER:  r_conn_filter  <= i_cfg_data;
                    CFG_SLOT_A:       r_slot[0]      <= i_cfg_data;
                    CFG_SLOT_B:       r_slot[1]      <= i_cfg_data;
                    CFG_SLOT_C:       r_slot[2]      <= i_cfg_data;
                    CFG_SLOT_D:       r_slot[3]      <= i_cfg_data;
                    CFG_SLOTS_IN_USE: r_slots_in_use <= i_cfg_data[2:0];
                    default: begin
                    end
                endcase
            end
            r_rp   <= n_rp;
            r_occ  <= n_occ;
            r_peak <= n_peak;
            r_acc  <= n_acc;
            r_drop <= n_drop;
            r_cap  <= n_cap;
            r_slen <= n_slen;
            r_sovf <= n_sovf;

            if (i_cmd.accept) begin
                r_idx <= '0;
            end else if (i_cmd.copy_rd || i_cmd.emit) begin
                r_idx <= r_idx + LW'(1);
            end
            r_wr_pend <= i_cmd.copy_rd;

            if (w_load) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_goes_copy) begin
            r_copy_len <= w_len_new;
            r_tail     <= w_tail;
        end
        if (i_cmd.accept && w_goes_read) begin
            r_slot_rd <= r_rp;
            r_now     <= w_now;
        end
        if (i_cmd.copy_rd) begin
            r_wr_idx <= r_idx;
        end
        if (i_cmd.age_calc) begin
            r_age <= r_now - r_stamp_rd;
        end
        if (w_load) begin
            r_o_kind   <= w_kind;
            r_o_handle <= w_o_handle;
            r_o_byte   <= w_o_byte;
            r_o_last   <= w_o_last;
            r_o_age    <= w_o_age;
            r_o_queued <= 7'(n_occ);
            r_o_peak   <= 7'(n_peak);
            r_o_recv   <= n_acc;
            r_o_drop   <= n_drop;
            r_o_filter <= n_cap;
        end
    end

    // staging buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (w_action == ACT_BEAT) && w_stage_wr) begin
            r_stg[r_slen[SW-1:0]] <= w_byte;
        end
        if (i_cmd.copy_rd) begin
            r_stg_rd <= r_stg[r_idx[SW-1:0]];
        end
    end

    // per-entry metadata
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_goes_copy) begin
            r_ring_hdl[w_tail]   <= w_handle;
            r_ring_len[w_tail]   <= w_len_new;
            r_ring_stamp[w_tail] <= w_now;
        end
        if (i_cmd.accept && w_goes_read) begin
            r_hdl_rd   <= r_ring_hdl[r_rp];
            r_len_rd   <= r_ring_len[r_rp];
            r_stamp_rd <= r_ring_stamp[r_rp];
        end
    end

    // report bytes
    always_ff @(posedge i_clk) begin
        if (r_wr_pend) begin
            r_ring_bytes[w_wr_addr] <= r_stg_rd;
        end
        if (w_byte_rd_en) begin
            r_byte_rd <= r_ring_bytes[w_rd_addr];
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tlast  = r_o_last;
    assign o_m_tuser  = r_o_kind;
    assign o_m_tdata  = {2'b00, r_o_filter, r_o_drop, r_o_recv, r_o_peak, r_o_queued,
                         r_o_age, r_o_byte, r_o_handle};

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(QUEUE_DEPTH))
        else $error("ring occupancy above depth");

    a_peak_covers_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_occ)
        else $error("peak depth below current occupancy");

    a_copy_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_wr_pend && i_cmd.accept))
        else $error("item accepted while ring copy still writing");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_ov || i_m_tready))
        else $error("report byte loaded over an untaken result");

endmodule

// ===== src/filtered_report_ring_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// filtered_report_ring_queue
// Filtered notification capture into a drop-oldest report ring.
// ============================================================================
// Usage:
//  - Slave stream carries one item per handshake: notification beats
//    (tuser action 0), reads of the oldest report (1) and disable (2).
//  - Master stream returns results; tuser is the result kind and tlast
//    marks the final result that one item causes.
//  - Config port writes conn filter, four handle slots and slot count; any
//    write to a known index re-arms capture and clears the ring and counters.
// Timing:
//  - A beat that is not last gives no result and leaves the block idle.
//  - Last beat, disable, read of an empty ring: result in the output
//    register the cycle after accept. A queued report then copies its
//    staged bytes into the ring one per cycle, busy until the last write.
//  - Read of a report: metadata, then age, then one byte per cycle while
//    the receiver takes them, through the byte memory's single read port.
// Reset clears control state and statistics; capture is off until the
// first write to a known config register. When the receiver stalls, the
// output register holds its result and tready stays low until it is taken.
// ============================================================================
module filtered_report_ring_queue
    import frrq_pkg::*;
#(
    parameter int QUEUE_DEPTH    = 64,
    parameter int MAX_REPORT_LEN = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [15:0] conn_id, [31:16] attr_handle, [39:32] report_byte,
    // [102:40] now_us, [103] zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] action, [2] byte_present
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    input  logic                   s_axis_tlast,   // last_beat
    // result items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [15:0] out_handle, [23:16] out_byte, [86:24] age_us,
    // [93:87] queued_now, [100:94] peak_depth, [132:101] received_total,
    // [164:133] dropped_total, [165] filter_on, [167:166] zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [2:0] kind
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,
    output logic                   m_axis_tlast    // last_of_run
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencer: owns the busy phases of copy and read-out
    frrq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // storage, statistics and the output register
    frrq_datapath #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .MAX_REPORT_LEN (MAX_REPORT_LEN)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_s_tlast   (s_axis_tlast),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser),
        .o_m_tlast   (m_axis_tlast),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

// ===== tb/tb_filtered_report_ring_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_filtered_report_ring_queue
// Self-checking bench for the filtered notification report ring.
// ============================================================================
// Drives notification beats, reads and disables into the slave stream and
// runs a cycle-free copy of the filter, staging buffer and drop-oldest ring
// alongside. Every item taken by the block is applied to that copy, which
// queues the results it must produce; each result on the master stream is
// compared field by field with the oldest queued one. Directed tests cover
// capture before arming, field extremes, empty and foreign reports, time
// wrap, disable, slot count limits and unknown codes; then a steady ring
// overflow run and random traffic under several filter settings follow.
// Both stream sides idle at random except during the overflow run.
// ============================================================================
module tb_filtered_report_ring_queue;
    import frrq_pkg::*;

    localparam int RING_SLOTS    = 64;
    localparam int REPORT_MAX    = 32;
    localparam int SETTLE_CYCLES = 40;   // longest ring copy plus margin

    // codes the package leaves unnamed
    localparam logic [1:0]           ACT_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct {
        logic [1:0]  action;
        logic [15:0] conn;
        logic [15:0] handle;
        logic [7:0]  data_byte;
        logic        present;
        logic        last;
        logic [62:0] stamp;
    } t_notify_item;

    typedef struct {
        logic [2:0]  kind;
        logic [15:0] handle;
        logic [7:0]  data_byte;
        logic        last;
        logic [62:0] age;
        logic [6:0]  depth;
        logic [6:0]  peak;
        logic [31:0] queued_total;
        logic [31:0] dropped;
        logic        capturing;
    } t_report_result;

    // ------------------------------------------------------------------------
    // Block ports, all known from time zero
    // ------------------------------------------------------------------------
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;

    filtered_report_ring_queue #(
        .QUEUE_DEPTH    (RING_SLOTS),
        .MAX_REPORT_LEN (REPORT_MAX)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow of the filter registers, staging buffer and ring
    // ------------------------------------------------------------------------
    logic [15:0] conn_sel = '0;
    logic [15:0] slot_handle [4] = '{default: '0};
    logic [2:0]  slot_count = '0;
    logic [7:0]  ring_data [RING_SLOTS][REPORT_MAX];
    logic [15:0] ring_handle [RING_SLOTS];
    int unsigned ring_len [RING_SLOTS];
    logic [62:0] ring_stamp [RING_SLOTS];
    int unsigned rd_ptr = 0;
    int unsigned occ = 0;
    int unsigned peak_occ = 0;
    logic [31:0] recv_count = '0;
    logic [31:0] drop_count = '0;
    logic        capture_on = 1'b0;
    logic [7:0]  stage_buf [REPORT_MAX];
    int unsigned stage_len = 0;
    logic        stage_ovf = 1'b0;

    t_report_result awaited_results [$];

    // run bookkeeping
    logic        steady = 1'b0;     // no idling on either side while set
    logic [62:0] clock_us = '0;
    int unsigned items_sent = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches = 0;
    int unsigned reports_queued = 0;
    int unsigned reports_passed = 0;
    int unsigned bytes_read = 0;
    int unsigned empty_reads = 0;
    int unsigned reports_dropped = 0;

    t_report_result seen, want;

    function automatic t_report_result stat_result(logic [2:0] kind, logic [15:0] handle,
            logic [7:0] data_byte, logic last, logic [62:0] age);
        t_report_result r;
        r.kind         = kind;
        r.handle       = handle;
        r.data_byte    = data_byte;
        r.last         = last;
        r.age          = age;
        r.depth        = 7'(occ);
        r.peak         = 7'(peak_occ);
        r.queued_total = recv_count;
        r.dropped      = drop_count;
        r.capturing    = capture_on;
        return r;
    endfunction

    // Any write to a known register re-arms capture and wipes the ring,
    // counters and staging; unknown indexes change nothing.
    function automatic void rearm_filter(logic [CFG_IDX_W-1:0] idx,
            logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_CONN_FILTER: conn_sel = value;
            CFG_SLOT_A, CFG_SLOT_B, CFG_SLOT_C, CFG_SLOT_D:
                slot_handle[idx - CFG_SLOT_A] = value;
            CFG_SLOTS_IN_USE: slot_count = value[2:0];
            default: return;
        endcase
        rd_ptr     = 0;
        occ        = 0;
        peak_occ   = 0;
        recv_count = '0;
        drop_count = '0;
        capture_on = 1'b1;
        stage_len  = 0;
        stage_ovf  = 1'b0;
    endfunction

    // Apply one accepted item and queue the results it must produce.
    function automatic void advance_ring_queue(t_notify_item it);
        int unsigned n, i, tail, slot, len;
        logic        hit;
        logic [62:0] age;
        hit = 1'b0;
        case (it.action)
            ACT_BEAT: begin
                if (it.present) begin
                    if (stage_len < REPORT_MAX) begin
                        stage_buf[stage_len] = it.data_byte;
                        stage_len++;
                    end else begin
                        stage_ovf = 1'b1;
                    end
                end
                if (it.last) begin
                    // slot count saturates at four, zero matches nothing
                    n = (slot_count > 3'd4) ? 4 : slot_count;
                    if (capture_on && it.conn == conn_sel)
                        for (i = 0; i < n; i++)
                            if (slot_handle[i] == it.handle) hit = 1'b1;
                    if (stage_len == 0 || stage_ovf || !hit) begin
                        stage_len = 0;
                        stage_ovf = 1'b0;
                        reports_passed++;
                        awaited_results.push_back(stat_result(KIND_PASSED, '0, '0, 1'b1, '0));
                    end else begin
                        // full ring: drop the oldest entry
                        if (occ >= RING_SLOTS) begin
                            rd_ptr = (rd_ptr + 1) % RING_SLOTS;
                            occ    = RING_SLOTS - 1;
                            drop_count++;
                            reports_dropped++;
                        end
                        tail = (rd_ptr + occ) % RING_SLOTS;
                        ring_handle[tail] = it.handle;
                        ring_len[tail]    = stage_len;
                        for (i = 0; i < stage_len; i++) ring_data[tail][i] = stage_buf[i];
                        ring_stamp[tail]  = it.stamp;
                        occ++;
                        recv_count++;
                        if (occ > peak_occ) peak_occ = occ;
                        stage_len = 0;
                        stage_ovf = 1'b0;
                        reports_queued++;
                        awaited_results.push_back(stat_result(KIND_QUEUED, '0, '0, 1'b1, '0));
                    end
                end
            end
            ACT_READ: begin
                if (occ == 0) begin
                    empty_reads++;
                    awaited_results.push_back(stat_result(KIND_EMPTY, '0, '0, 1'b1, '0));
                end else begin
                    slot   = rd_ptr;
                    len    = ring_len[slot];
                    age    = it.stamp - ring_stamp[slot];   // wraps at 63 bits
                    rd_ptr = (slot + 1) % RING_SLOTS;
                    occ--;
                    for (i = 0; i < len; i++)
                        awaited_results.push_back(stat_result(KIND_BYTE, ring_handle[slot],
                            ring_data[slot][i], (i + 1 == len), age));
                    bytes_read += len;
                end
            end
            ACT_DISABLE: begin
                capture_on = 1'b0;
                rd_ptr     = 0;
                occ        = 0;
                awaited_results.push_back(stat_result(KIND_DISABLED, '0, '0, 1'b1, '0));
            end
            default: ;   // unused action: no result, no state change
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and the field-by-field check
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (steady) m_axis_tready <= 1'b1;
        else        m_axis_tready <= ($urandom_range(99) >= 9);
    end

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
        mismatches++;
        $display("MISMATCH at %0t: %s got %0h, wanted %0h", $time, what, got, exp_val);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.kind         = m_axis_tuser[2:0];
            seen.last         = m_axis_tlast;
            seen.handle       = m_axis_tdata[15:0];
            seen.data_byte    = m_axis_tdata[23:16];
            seen.age          = m_axis_tdata[86:24];
            seen.depth        = m_axis_tdata[93:87];
            seen.peak         = m_axis_tdata[100:94];
            seen.queued_total = m_axis_tdata[132:101];
            seen.dropped      = m_axis_tdata[164:133];
            seen.capturing    = m_axis_tdata[165];
            results_checked++;
            if (awaited_results.size() == 0) begin
                flag_mismatch("result with nothing pending, kind", seen.kind, '0);
            end else begin
                want = awaited_results.pop_front();
                if (seen.kind !== want.kind) flag_mismatch("kind", seen.kind, want.kind);
                if (seen.handle !== want.handle)
                    flag_mismatch("out_handle", seen.handle, want.handle);
                if (seen.data_byte !== want.data_byte)
                    flag_mismatch("out_byte", seen.data_byte, want.data_byte);
                if (seen.last !== want.last) flag_mismatch("last_of_run", seen.last, want.last);
                if (seen.age !== want.age) flag_mismatch("age_us", seen.age, want.age);
                if (seen.depth !== want.depth)
                    flag_mismatch("queued_now", seen.depth, want.depth);
                if (seen.peak !== want.peak) flag_mismatch("peak_depth", seen.peak, want.peak);
                if (seen.queued_total !== want.queued_total)
                    flag_mismatch("received_total", seen.queued_total, want.queued_total);
                if (seen.dropped !== want.dropped)
                    flag_mismatch("dropped_total", seen.dropped, want.dropped);
                if (seen.capturing !== want.capturing)
                    flag_mismatch("filter_on", seen.capturing, want.capturing);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Item side
    // ------------------------------------------------------------------------
    // Advance the microsecond clock; now and then jump anywhere in 63 bits.
    function automatic logic [62:0] next_stamp();
        if ($urandom_range(99) < 3) clock_us = 63'({$urandom, $urandom});
        else                        clock_us = clock_us + 63'($urandom_range(500));
        return clock_us;
    endfunction

    function automatic t_notify_item make_item(logic [1:0] action, logic [15:0] conn,
            logic [15:0] handle, logic [7:0] data_byte, logic present, logic last);
        t_notify_item it;
        it.action    = action;
        it.conn      = conn;
        it.handle    = handle;
        it.data_byte = data_byte;
        it.present   = present;
        it.last      = last;
        it.stamp     = next_stamp();
        return it;
    endfunction

    // Offer one item, hold it until taken, then apply it to the shadow.
    // Valid stays high on return so back-to-back items never toggle it.
    task automatic push_item(t_notify_item it);
        if (!steady && $urandom_range(99) < 9) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, it.stamp, it.data_byte, it.handle, it.conn};
        s_axis_tuser  <= {it.present, it.action};
        s_axis_tlast  <= it.last;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
        advance_ring_queue(it);
        items_sent++;
    endtask

    // Drop valid, wait for every pending result, then let a ring copy finish.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        drain_results();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        rearm_filter(idx, value);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic arm_filter(logic [15:0] conn, logic [15:0] a, logic [15:0] b,
            logic [15:0] c, logic [15:0] d, logic [15:0] count);
        write_reg(CFG_CONN_FILTER, conn);
        write_reg(CFG_SLOT_A, a);
        write_reg(CFG_SLOT_B, b);
        write_reg(CFG_SLOT_C, c);
        write_reg(CFG_SLOT_D, d);
        write_reg(CFG_SLOTS_IN_USE, count);
    endtask

    // A report of len payload bytes; the last beat carries the final byte,
    // or no byte at all for an empty report. Ragged reports mix in beats
    // without a byte.
    task automatic send_report(logic [15:0] conn, logic [15:0] handle, int unsigned len,
            bit ragged);
        int unsigned k;
        for (k = 1; k < len; k++) begin
            if (ragged && $urandom_range(99) < 10)
                push_item(make_item(ACT_BEAT, 16'($urandom), 16'($urandom), 8'($urandom),
                    1'b0, 1'b0));
            push_item(make_item(ACT_BEAT, 16'($urandom), 16'($urandom), 8'($urandom),
                1'b1, 1'b0));
        end
        push_item(make_item(ACT_BEAT, conn, handle, 8'($urandom), len != 0, 1'b1));
    endtask

    task automatic request_read();
        push_item(make_item(ACT_READ, 16'($urandom), 16'($urandom), 8'($urandom),
            1'($urandom), 1'($urandom)));
    endtask

    task automatic request_disable();
        push_item(make_item(ACT_DISABLE, 16'($urandom), 16'($urandom), 8'($urandom),
            1'($urandom), 1'($urandom)));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Capture is off out of reset: everything is passed on, the ring is empty.
    task automatic test_idle_before_arm();
        send_report(16'h0000, 16'h0000, 2, 0);
        request_read();
        push_item(make_item(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1));
        request_disable();
    endtask

    task automatic test_filter_edges();
        t_notify_item it;
        arm_filter(16'hFFFF, 16'h0000, 16'hFFFF, 16'h1234, 16'hABCD, 16'd4);
        // one-byte report on slot a, stamped just short of the time wrap
        it = make_item(ACT_BEAT, 16'hFFFF, 16'h0000, 8'h00, 1'b1, 1'b1);
        it.stamp = 63'h7FFF_FFFF_FFFF_FFF0;
        push_item(it);
        // two bytes on slot b with an empty beat between them
        push_item(make_item(ACT_BEAT, 16'h0000, 16'h0000, 8'hFF, 1'b1, 1'b0));
        push_item(make_item(ACT_BEAT, 16'h5555, 16'hAAAA, 8'h3C, 1'b0, 1'b0));
        push_item(make_item(ACT_BEAT, 16'hFFFF, 16'hFFFF, 8'h80, 1'b1, 1'b1));
        send_report(16'hFFFF, 16'hABCD, 1, 0);
        // empty report, foreign connection, unregistered handle: passed on
        send_report(16'hFFFF, 16'h0000, 0, 0);
        send_report(16'hFFFE, 16'h0000, 1, 0);
        send_report(16'hFFFF, 16'h1235, 1, 0);
        // read the first report at a time past the wrap
        it = make_item(ACT_READ, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0);
        it.stamp = 63'd5;
        push_item(it);
        repeat (3) request_read();
        push_item(make_item(ACT_UNUSED, 16'($urandom), 16'($urandom), 8'($urandom),
            1'b0, 1'b0));
        // hold off until the block has answered everything so far
        drain_results();
        send_report(16'hFFFF, 16'h0000, 1, 0);
        request_disable();
        // capture now off: a matching report is passed on, ring reads empty
        send_report(16'hFFFF, 16'h0000, 1, 0);
        request_read();
    endtask

    task automatic test_slot_count_limits();
        // zero slots match nothing
        arm_filter(16'h0000, 16'hFFFF, 16'h0001, 16'h0002, 16'hFFFE, 16'd0);
        send_report(16'h0000, 16'hFFFF, 1, 0);
        // count seven saturates at four: slot d is compared
        write_reg(CFG_SLOTS_IN_USE, 16'hFFFF);
        send_report(16'h0000, 16'hFFFE, 1, 0);
        // only slot a
        write_reg(CFG_SLOTS_IN_USE, 16'd1);
        send_report(16'h0000, 16'h0001, 1, 0);
        send_report(16'h0000, 16'hFFFF, 3, 0);
        // unknown register index leaves ring and counters alone
        write_reg(CFG_UNUSED, 16'($urandom));
        request_read();
        write_reg(CFG_SLOTS_IN_USE, 16'd5);
        send_report(16'h0000, 16'h0002, 1, 0);
    endtask

    // Overrun the ring with no idling on either side, then read past the
    // drops into a full-size report.
    task automatic test_ring_overflow();
        int unsigned i;
        steady = 1'b1;
        arm_filter(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
            16'($urandom), 16'd4);
        for (i = 0; i < 70; i++)
            send_report(conn_sel, slot_handle[i % 4], (i == 10 || i == 40) ? REPORT_MAX : 1, 0);
        repeat (5) request_read();
        drain_results();
        steady = 1'b0;
    endtask

    // Mostly well-formed reports with random content and reads; the rest is
    // raw noise beats of any action that also breaks reports apart.
    task automatic random_sequence();
        int unsigned pick, len;
        logic [15:0] conn, handle;
        pick = $urandom_range(99);
        if (pick < 55) begin
            conn   = ($urandom_range(99) < 85) ? conn_sel : 16'($urandom);
            handle = ($urandom_range(99) < 85) ? slot_handle[$urandom_range(3)]
                                               : 16'($urandom);
            pick = $urandom_range(99);
            if (pick < 70)      len = $urandom_range(8, 1);
            else if (pick < 92) len = $urandom_range(REPORT_MAX, 9);
            else if (pick < 96) len = 0;
            else                len = $urandom_range(REPORT_MAX + 3, REPORT_MAX + 1);
            send_report(conn, handle, len, 1);
        end else if (pick < 88) begin
            request_read();
        end else if (pick < 89) begin
            request_disable();
        end else begin
            push_item(make_item(2'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                1'($urandom), 1'($urandom)));
        end
    endtask

    task automatic test_random_traffic();
        int unsigned phase, stop_at;
        logic [15:0] count;
        for (phase = 0; phase < 4; phase++) begin
            count = (phase == 3) ? 16'($urandom_range(7)) : 16'(phase + 2);
            arm_filter(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), count);
            stop_at = items_sent + 70;
            while (items_sent < stop_at) random_sequence();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_idle_before_arm();
        test_filter_edges();
        test_slot_count_limits();
        test_ring_overflow();
        test_random_traffic();
        drain_results();

        $display("Covered %0d items and %0d results: %0d reports queued, %0d passed on.",
            items_sent, results_checked, reports_queued, reports_passed);
        $display("Read back %0d report bytes, %0d empty reads, %0d oldest reports dropped.",
            bytes_read, empty_reads, reports_dropped);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
